>>> design/bit_reservoir_step_unit_macros.svh
// Assertion macros for the checker of the bit reservoir step unit.
`ifndef BIT_RESERVOIR_STEP_UNIT_MACROS_SVH
`define BIT_RESERVOIR_STEP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("brsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRSU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("brsu assertion failed");

`endif

>>> design/brsu_pkg.sv
// Types, constants and helper functions of the bit reservoir step unit.
package brsu_pkg;

    localparam int BUFFER_BITS = 8;
    localparam int RES_W       = BUFFER_BITS + 1;
    localparam int CNT_W       = $clog2(BUFFER_BITS + 1);
    localparam int VALUE_W     = BUFFER_BITS;
    localparam int SIZE_W      = 4;
    localparam int REQ_W       = 4;

    typedef logic [BUFFER_BITS-1:0] t_buf;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [RES_W-1:0]       t_res;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_UNREAD = 2'd1,
        ACT_UNARY  = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]       action;
        t_res             packed_reservoir;
        logic [REQ_W-1:0] bit_count;
        logic             bit_value;
    } t_step_in;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic [SIZE_W-1:0]  result_size;
        t_res               next_reservoir;
        logic               res_full;
        logic               need_more;
    } t_step_out;

    // Ones in the n lowest positions.
    function automatic t_buf low_mask(input t_cnt n);
        t_buf m;
        for (int j = 0; j < BUFFER_BITS; j++) begin
            m[j] = (j < n);
        end
        return m;
    endfunction

    // Packs n valid bits under a marker bit; an empty reservoir packs to zero.
    function automatic t_res pack(input t_cnt n, input t_buf b);
        t_res r;
        t_res pad;
        pad = {1'b0, b};
        for (int j = 0; j < RES_W; j++) begin
            r[j] = (j < n) ? pad[j] : ((j == n) && (n != '0));
        end
        return r;
    endfunction

endpackage

>>> design/brsu_core.sv
// Combinational step logic: size decode, bit read, unread and unary scan.
module brsu_core
    import brsu_pkg::*;
(
    input  t_step_in  i_item,
    input  logic      i_msb_first,
    output t_step_out o_result
);

    t_cnt             size;
    t_buf             bits;
    t_cnt             req;
    t_cnt             rest;
    t_buf             match;
    t_cnt             hi;
    t_cnt             lo;
    logic             found;
    logic             bv;

    always_comb begin
        // The highest set bit above position zero is the marker.
        size = '0;
        for (int k = 1; k <= BUFFER_BITS; k++) begin
            if (i_item.packed_reservoir[k]) begin
                size = CNT_W'(k);
            end
        end
        bits  = i_item.packed_reservoir[BUFFER_BITS-1:0] & low_mask(size);
        req   = CNT_W'(i_item.bit_count);
        rest  = size - req;
        bv    = i_item.bit_value;

        for (int j = 0; j < BUFFER_BITS; j++) begin
            match[j] = (j < size) && (bits[j] == bv);
        end
        found = |match;
        hi = '0;
        for (int j = 0; j < BUFFER_BITS; j++) begin
            if (match[j]) begin
                hi = CNT_W'(j);
            end
        end
        lo = '0;
        for (int j = BUFFER_BITS - 1; j >= 0; j--) begin
            if (match[j]) begin
                lo = CNT_W'(j);
            end
        end

        o_result = '0;
        case (i_item.action)
            ACT_READ: begin
                if (size == '0) begin
                    o_result = '0;
                end else if (i_item.bit_count >= SIZE_W'(size)) begin
                    o_result.result_size  = SIZE_W'(size);
                    o_result.result_value = bits;
                end else begin
                    o_result.result_size = i_item.bit_count;
                    if (i_msb_first) begin
                        o_result.result_value   = bits >> rest;
                        o_result.next_reservoir = pack(rest, bits);
                    end else begin
                        o_result.result_value   = bits & low_mask(req);
                        o_result.next_reservoir = pack(rest, bits >> req);
                    end
                end
            end
            ACT_UNREAD: begin
                if (size < CNT_W'(BUFFER_BITS)) begin
                    if (i_msb_first) begin
                        o_result.next_reservoir =
                            pack(size + CNT_W'(1), bits | (t_buf'(bv) << size));
                    end else begin
                        o_result.next_reservoir =
                            pack(size + CNT_W'(1), (bits << 1) | t_buf'(bv));
                    end
                end else begin
                    o_result.res_full       = 1'b1;
                    o_result.next_reservoir = pack(size, bits);
                end
            end
            ACT_UNARY: begin
                if (!found) begin
                    // Ran out of bits before the stop bit.
                    o_result.need_more    = 1'b1;
                    o_result.result_value = VALUE_W'(size);
                end else if (i_msb_first) begin
                    o_result.result_value   = VALUE_W'(CNT_W'(size - CNT_W'(1) - hi));
                    o_result.next_reservoir = pack(hi, bits);
                end else begin
                    o_result.result_value   = VALUE_W'(lo);
                    o_result.next_reservoir =
                        pack(CNT_W'(size - CNT_W'(1) - lo), bits >> (lo + CNT_W'(1)));
                end
            end
            default: begin
                o_result.next_reservoir = pack(size, bits);
            end
        endcase
    end

endmodule

>>> design/bit_reservoir_step_unit.sv
// Top level of the bit reservoir step unit: input register, step logic, result register.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------
//  input     | start / busy              | i_item (t_step_in)
//  result    | o_result_strobe           | o_result (t_step_out)
//  config    | i_cfg_we                  | i_cfg_wdata
//
// One transaction is accepted every cycle; busy stays low.
// A result passes through the input register and then the result register before it is
// shown.
// Synchronous active-low reset clears the valid flags and sets big-endian mode.
// The receiver takes every result in the cycle it is shown.
module bit_reservoir_step_unit
    import brsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_step_in  i_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    output logic      o_result_strobe,
    output t_step_out o_result
);

    logic      r_msb_first;
    logic      r_in_vld;
    t_step_in  r_in;
    logic      r_out_vld;
    t_step_out r_out;
    t_step_out n_out;

    assign busy = 1'b0;

    brsu_core u_core (
        .i_item      (r_in),
        .i_msb_first (r_msb_first),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first <= 1'b1;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_msb_first <= i_cfg_wdata;
            end
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_result_strobe = r_out_vld;
    assign o_result        = r_out;

endmodule

>>> design/brsu_checker.sv
// Port-level checker of the bit reservoir step unit and its bind statement.
`include "bit_reservoir_step_unit_macros.svh"

module brsu_checker
    import brsu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_result_strobe,
    input t_step_out o_result
);

    logic              both_flags;
    logic [SIZE_W-1:0] shown_size;

    assign both_flags = o_result.res_full && o_result.need_more;
    assign shown_size = o_result.result_size;

    // Every accepted transaction yields a result once it has passed the input and result registers.
    `BRSU_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, start && !busy, ##1 o_result_strobe)

    // No result is shown without an accepted transaction ahead of it in the input and result registers.
    `BRSU_ASSERT_IMP(a_no_spurious, i_clk, i_rst_n, o_result_strobe, $past(start && !busy, 2))

    // A full unread and an exhausted unary read cannot happen in one step.
    `BRSU_ASSERT_IMP(a_flags_exclusive, i_clk, i_rst_n, o_result_strobe, !both_flags)

    // Never more bits delivered than the reservoir can hold.
    `BRSU_ASSERT_IMP(a_size_bound, i_clk, i_rst_n, o_result_strobe, shown_size <= SIZE_W'(8))

endmodule

bind bit_reservoir_step_unit brsu_checker u_brsu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_result        (o_result)
);

>>> test/bit_reservoir_step_unit_tb.sv
// Self-checking testbench for the bit reservoir step unit.
module bit_reservoir_step_unit_tb
    import brsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The action field is two bits wide; its fourth code is not a defined action.
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam int ITEMS_PER_PHASE = 384;
    localparam int NUM_PHASES = 4;

    typedef struct {
        t_step_in  item;
        bit        known;
        t_step_out want;
    } t_script_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_step_in  i_item = '0;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      o_result_strobe;
    t_step_out o_result;

    t_step_out   pending_results[$];
    t_script_row script[$];
    logic        msb_mode = 1'b1;
    int          mismatches = 0;

    // Sender idle percentage and endian setting for each random phase. The
    // receiver cannot hold results off, so its stall phase runs without gaps.
    int   phase_idle[NUM_PHASES] = '{0, 78, 0, 33};
    logic phase_mode[NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1};

    bit_reservoir_step_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Marker bit above the n low bits of b; an empty reservoir is zero.
    function automatic t_res canonical(input int n, input int b);
        if (n == 0) begin
            return '0;
        end
        return t_res'((1 << n) | (b & ((1 << n) - 1)));
    endfunction

    function automatic t_step_out reservoir_step(input t_step_in it, input logic msb_first);
        t_step_out r;
        int size;
        int bits;
        int req;
        int bv;
        int rest;
        int pos;
        bit found;
        r = '0;
        size = 0;
        for (int k = BUFFER_BITS; k > 0; k--) begin
            if (size == 0 && it.packed_reservoir[k]) begin
                size = k;
            end
        end
        bits = int'(it.packed_reservoir) & ((1 << size) - 1);
        req = int'(it.bit_count);
        bv = int'(it.bit_value);
        case (it.action)
            ACT_READ: begin
                if (size != 0 && req >= size) begin
                    r.result_size = SIZE_W'(size);
                    r.result_value = VALUE_W'(bits);
                end else if (size != 0) begin
                    rest = size - req;
                    r.result_size = SIZE_W'(req);
                    if (msb_first) begin
                        r.result_value = VALUE_W'(bits >> rest);
                        r.next_reservoir = canonical(rest, bits);
                    end else begin
                        r.result_value = VALUE_W'(bits & ((1 << req) - 1));
                        r.next_reservoir = canonical(rest, bits >> req);
                    end
                end
            end
            ACT_UNREAD: begin
                if (size < BUFFER_BITS) begin
                    r.next_reservoir = msb_first ? canonical(size + 1, bits | (bv << size))
                                                 : canonical(size + 1, (bits << 1) | bv);
                end else begin
                    r.res_full = 1'b1;
                    r.next_reservoir = canonical(size, bits);
                end
            end
            ACT_UNARY: begin
                found = 1'b0;
                for (int i = 0; i < size && !found; i++) begin
                    pos = msb_first ? size - i - 1 : i;
                    if (((bits >> pos) & 1) == bv) begin
                        found = 1'b1;
                        r.next_reservoir = msb_first ? canonical(pos, bits)
                                                     : canonical(size - i - 1, bits >> (i + 1));
                    end else begin
                        r.result_value = r.result_value + VALUE_W'(1);
                    end
                end
                r.need_more = !found;
            end
            default: begin
                r.next_reservoir = canonical(size, bits);
            end
        endcase
        return r;
    endfunction

    function automatic t_step_in make_item(input logic [1:0] act, input t_res res,
                                           input logic [REQ_W-1:0] cnt, input logic bv);
        t_step_in it;
        it.action = act;
        it.packed_reservoir = res;
        it.bit_count = cnt;
        it.bit_value = bv;
        return it;
    endfunction

    function automatic t_step_in random_item();
        logic [1:0] act;
        t_res res;
        logic [REQ_W-1:0] cnt;
        act = ($urandom_range(0, 9) == 0) ? ACT_UNDEFINED : 2'($urandom_range(0, 2));
        // Mostly well-formed reservoirs of every size, some raw codes.
        if ($urandom_range(0, 4) == 0) begin
            res = t_res'($urandom_range(0, 511));
        end else begin
            res = canonical($urandom_range(0, BUFFER_BITS), $urandom);
        end
        cnt = ($urandom_range(0, 3) == 0) ? REQ_W'($urandom_range(0, 15))
                                          : REQ_W'($urandom_range(1, BUFFER_BITS));
        return make_item(act, res, cnt, 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_item(input t_step_in it, input bit known, input t_step_out want,
                             input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(known ? want : reservoir_step(it, msb_mode));
    endtask

    // The block is idle once every result has come back; the task then waits
    // out the pipeline before the endian register is changed.
    task automatic write_endian(input logic mode);
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        msb_mode = mode;
    endtask

    always @(posedge i_clk) begin
        t_step_out want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, actual %p", $time, o_result);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.result_value !== want.result_value) begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.result_value, o_result.result_value);
                    mismatches++;
                end
                if (o_result.result_size !== want.result_size) begin
                    $display("%0t: result_size expected %0d actual %0d",
                             $time, want.result_size, o_result.result_size);
                    mismatches++;
                end
                if (o_result.next_reservoir !== want.next_reservoir) begin
                    $display("%0t: next_reservoir expected %h actual %h",
                             $time, want.next_reservoir, o_result.next_reservoir);
                    mismatches++;
                end
                if (o_result.res_full !== want.res_full) begin
                    $display("%0t: res_full expected %b actual %b",
                             $time, want.res_full, o_result.res_full);
                    mismatches++;
                end
                if (o_result.need_more !== want.need_more) begin
                    $display("%0t: need_more expected %b actual %b",
                             $time, want.need_more, o_result.need_more);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        // Rows with a typed result hold for either endian setting.
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h000, 4'd8, 1'b0), 1'b1,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h001, 4'd1, 1'b1), 1'b1,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h1FF, 4'd8, 1'b0), 1'b1,
                                       t_step_out'{8'hFF, 4'd8, 9'h000, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h1FF, 4'd0, 1'b0), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h1FF, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h100, 4'd15, 1'b1), 1'b1,
                                       t_step_out'{8'h00, 4'd8, 9'h000, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h1A5, 4'd3, 1'b0), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h00B, 4'd2, 1'b1), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h055, 4'd9, 1'b0), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_READ, 9'h010, 4'd4, 1'b0), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_UNREAD, 9'h1FF, 4'd0, 1'b1), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h1FF, 1'b1, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_UNREAD, 9'h000, 4'd0, 1'b1), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h003, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_UNREAD, 9'h001, 4'd15, 1'b0), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h002, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_UNREAD, 9'h0AA, 4'd1, 1'b1), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_UNREAD, 9'h0D5, 4'd7, 1'b0), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_UNARY, 9'h000, 4'd0, 1'b1), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h000, 1'b0, 1'b1}});
        script.push_back(t_script_row'{make_item(ACT_UNARY, 9'h1FF, 4'd0, 1'b0), 1'b1,
                                       t_step_out'{8'h08, 4'd0, 9'h000, 1'b0, 1'b1}});
        script.push_back(t_script_row'{make_item(ACT_UNARY, 9'h1FF, 4'd0, 1'b1), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h0FF, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_UNARY, 9'h101, 4'd0, 1'b1), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_UNARY, 9'h003, 4'd8, 1'b1), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_UNARY, 9'h0B4, 4'd2, 1'b0), 1'b0,
                                       t_step_out'('0)});
        script.push_back(t_script_row'{make_item(ACT_UNDEFINED, 9'h1FF, 4'd15, 1'b1), 1'b1,
                                       t_step_out'{8'h00, 4'd0, 9'h1FF, 1'b0, 1'b0}});
        script.push_back(t_script_row'{make_item(ACT_UNDEFINED, 9'h001, 4'd8, 1'b0), 1'b1,
                                       t_step_out'('0)});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            send_item(script[i].item, script[i].known, script[i].want, 0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_endian(phase_mode[p]);
            repeat (ITEMS_PER_PHASE) begin
                send_item(random_item(), 1'b0, t_step_out'('0), phase_idle[p]);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/brsu_pkg.sv
design/brsu_core.sv
design/bit_reservoir_step_unit.sv
design/brsu_checker.sv
test/bit_reservoir_step_unit_tb.sv
